// ----- design/sparse_format_matrix_element_access_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sparse matrix element access block
// Two checks: one in the same cycle, one in the next cycle. Both compile
// to nothing when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef SPARSE_FORMAT_MATRIX_ELEMENT_ACCESS_ASSERT_SVH
`define SPARSE_FORMAT_MATRIX_ELEMENT_ACCESS_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SFMA_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define SFMA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SFMA_ASSERT_SAME(label, clk, rstn, ante, cons, msg)
`define SFMA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

// ----- design/sfma_pkg.sv -----
// ----------------------------------------------------------------------------
// sfma_pkg
// Shared types, codes and widths of the sparse matrix element access block.
// ----------------------------------------------------------------------------
package sfma_pkg;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 48;
    localparam int ADDR_OUT_W  = 12;
    localparam int DIM_W       = 9;
    localparam int CALC_W      = 24;
    localparam int MUL_A_W     = 8;
    localparam int MUL_B_W     = 11;
    localparam int PROD_W      = MUL_A_W + 1 + MUL_B_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // storage modes
    localparam logic [2:0] MODE_ZERO   = 3'd0;
    localparam logic [2:0] MODE_DIAG   = 3'd1;
    localparam logic [2:0] MODE_BAND   = 3'd2;
    localparam logic [2:0] MODE_STRIPE = 3'd3;
    localparam logic [2:0] MODE_DENSE  = 3'd4;

    // item functions
    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_LOAD  = 2'd2;

    // what the back end does with a queued item
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_STORAGE_MODE = 3'd0;
    localparam logic [2:0] REG_COLUMN_MAJOR = 3'd1;
    localparam logic [2:0] REG_NUM_ROWS     = 3'd2;
    localparam logic [2:0] REG_NUM_COLS     = 3'd3;
    localparam logic [2:0] REG_STRIPE_COUNT = 3'd4;

    typedef logic signed [CALC_W-1:0]  calc_t;
    typedef logic signed [MUL_B_W-1:0] mulb_t;
    typedef logic signed [8:0]         off_t;

    typedef struct packed {
        logic [2:0]       storage_mode;
        logic             column_major;
        logic [DIM_W-1:0] num_rows;
        logic [DIM_W-1:0] num_cols;
        logic [3:0]       stripe_count;
    } cfg_t;

    // address = base + mul_a * mul_b, valid when hit_pre and inside the store
    typedef struct packed {
        logic [1:0]         kind;
        logic               hit_pre;
        calc_t              base;
        logic [MUL_A_W-1:0] mul_a;
        mulb_t              mul_b;
        logic [31:0]        wdata;
    } qent_t;

endpackage

// ----- design/sfma_ram.sv -----
// ----------------------------------------------------------------------------
// sfma_ram
// Single-port RAM with registered read; read data holds between reads.
// ----------------------------------------------------------------------------
module sfma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                      wdata,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/sfma_queue.sv -----
// ----------------------------------------------------------------------------
// sfma_queue
// Short FIFO of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module sfma_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  sfma_pkg::qent_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output sfma_pkg::qent_t head
);
    import sfma_pkg::*;

    qent_t             ent_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = ent_reg[rd_ptr_reg];

    always_comb begin
        do_push     = push && !full;
        do_pop      = pop && valid;
        wr_ptr_next = do_push ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = QCNT_W'(count_reg + 1'b1);
        end else if (do_pop && !do_push) begin
            count_next = QCNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- design/sfma_front.sv -----
// ----------------------------------------------------------------------------
// sfma_front
// Accepts items, holds the stripe table and reduces each access to a
// base, a product of two operands and a provisional hit.
// ----------------------------------------------------------------------------
module sfma_front #(
    parameter int MAX_DIM     = 256,
    parameter int MAX_STRIPES = 8
) (
    input  logic                               aclk,
    input  sfma_pkg::cfg_t                     cfg,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // row[7:0], col[15:8], write_value[47:16], stripe_slot[50:48],
    // stripe_offset[59:51], zero fill[63:60]
    input  logic [sfma_pkg::IN_TDATA_W-1:0]    s_tdata,
    // func[1:0]
    input  logic [1:0]                         s_tuser,
    output logic                               push,
    output sfma_pkg::qent_t                    push_data,
    input  logic                               q_full
);
    import sfma_pkg::*;

    localparam int SLOT_W = (MAX_STRIPES > 1) ? $clog2(MAX_STRIPES) : 1;

    off_t              stripe_tab_reg [MAX_STRIPES];

    logic [7:0]        row, col;
    logic [31:0]       wval;
    logic [2:0]        slot;
    off_t              off;
    logic              slot_ok;
    logic [DIM_W-1:0]  nr, nc, nmin;
    logic              in_dims;
    calc_t             rc, cc, diff, kl, ku, bw;
    logic              found;
    logic [SLOT_W-1:0] k;
    qent_t             ent;

    assign row  = s_tdata[7:0];
    assign col  = s_tdata[15:8];
    assign wval = s_tdata[47:16];
    assign slot = s_tdata[50:48];
    assign off  = s_tdata[59:51];

    assign s_tready = !q_full;
    assign push     = s_tvalid && s_tready;
    assign slot_ok  = (32'(slot) < MAX_STRIPES);

    always_comb begin
        nr   = (32'(cfg.num_rows) > MAX_DIM) ? DIM_W'(MAX_DIM) : cfg.num_rows;
        nc   = (32'(cfg.num_cols) > MAX_DIM) ? DIM_W'(MAX_DIM) : cfg.num_cols;
        nmin = (nr < nc) ? nr : nc;
        in_dims = ({1'b0, row} < nr) && ({1'b0, col} < nc);

        rc   = calc_t'(row);
        cc   = calc_t'(col);
        diff = cc - rc;
        kl   = calc_t'(stripe_tab_reg[0]);
        ku   = calc_t'(stripe_tab_reg[1]);
        bw   = kl + ku + calc_t'(1);

        // lowest matching stripe wins
        found = 1'b0;
        k     = '0;
        for (int i = MAX_STRIPES - 1; i >= 0; i--) begin
            if ((i < int'(cfg.stripe_count)) && (calc_t'(stripe_tab_reg[i]) == diff)) begin
                found = 1'b1;
                k     = SLOT_W'(i);
            end
        end

        ent.kind    = KIND_NONE;
        ent.hit_pre = 1'b0;
        ent.base    = '0;
        ent.mul_a   = '0;
        ent.mul_b   = '0;
        ent.wdata   = wval;

        case (cfg.storage_mode)
            MODE_DIAG: begin
                ent.hit_pre = (row == col);
                ent.base    = rc;
            end
            MODE_BAND: begin
                ent.mul_b = mulb_t'(bw);
                if (!cfg.column_major) begin
                    ent.hit_pre = (rc - kl <= cc) && (cc <= rc + ku);
                    ent.base    = cc - rc + kl;
                    ent.mul_a   = row;
                end else begin
                    ent.hit_pre = (cc - ku <= rc) && (rc <= cc + kl);
                    ent.base    = rc - cc + ku;
                    ent.mul_a   = col;
                end
                // banded writes are dropped
                if (s_tuser == FUNC_WRITE) begin
                    ent.hit_pre = 1'b0;
                end
            end
            MODE_STRIPE: begin
                ent.hit_pre = found;
                ent.base    = diff[CALC_W-1] ? cc : rc;
                ent.mul_a   = MUL_A_W'(k);
                ent.mul_b   = mulb_t'({2'b00, nmin});
            end
            MODE_DENSE: begin
                ent.hit_pre = 1'b1;
                if (!cfg.column_major) begin
                    ent.base  = cc;
                    ent.mul_a = row;
                    ent.mul_b = mulb_t'({2'b00, nc});
                end else begin
                    ent.base  = rc;
                    ent.mul_a = col;
                    ent.mul_b = mulb_t'({2'b00, nr});
                end
            end
            default: begin
                ent.hit_pre = 1'b0;
            end
        endcase

        case (s_tuser)
            FUNC_READ:  ent.kind = KIND_READ;
            FUNC_WRITE: ent.kind = KIND_WRITE;
            default: begin
                ent.kind    = KIND_NONE;
                ent.hit_pre = 1'b0;
            end
        endcase
        ent.hit_pre = ent.hit_pre && in_dims;
    end

    assign push_data = ent;

    // table loads take effect in item order, ahead of later lookups
    always_ff @(posedge aclk) begin
        if (push && (s_tuser == FUNC_LOAD) && slot_ok) begin
            stripe_tab_reg[SLOT_W'(slot)] <= off;
        end
    end

endmodule

// ----- design/sfma_back.sv -----
`include "sparse_format_matrix_element_access_assert.svh"
// ----------------------------------------------------------------------------
// sfma_back
// Multiplies out the address, checks it against the store, accesses the
// element RAM and holds the result beat until it is taken.
// ----------------------------------------------------------------------------
module sfma_back #(
    parameter int STORE_DEPTH = 4096,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             q_valid,
    input  sfma_pkg::qent_t                  q_head,
    output logic                             q_pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // read_value[31:0], address[43:32], zero fill[47:44]
    output logic [sfma_pkg::OUT_TDATA_W-1:0] m_tdata,
    // hit[0]
    output logic                             m_tuser
);
    import sfma_pkg::*;

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    calc_t                   base_reg;
    logic                    hit_pre_reg;
    logic [1:0]              kind_reg;
    logic [31:0]             wdata_reg;
    logic                    out_hit_reg;
    logic                    out_rd_reg;
    logic [ADDR_OUT_W-1:0]   out_addr_reg;

    logic signed [MUL_A_W:0] mul_a_s;
    calc_t                   sum;
    logic                    in_store, acc_hit;
    logic                    ram_we, ram_re;
    logic [VALUE_WIDTH-1:0]  ram_rdata;
    logic [31:0]             read_value;

    always_comb begin
        q_pop     = q_valid && ((state_reg == ST_IDLE) || ((state_reg == ST_OUT) && m_tready));
        mul_a_s   = {1'b0, q_head.mul_a};
        prod_next = PROD_W'(mul_a_s) * PROD_W'(q_head.mul_b);

        sum      = base_reg + calc_t'(prod_reg);
        in_store = !sum[CALC_W-1] && (sum < calc_t'(STORE_DEPTH));
        acc_hit  = hit_pre_reg && in_store;
        ram_re   = (state_reg == ST_CALC) && acc_hit && (kind_reg == KIND_READ);
        ram_we   = (state_reg == ST_CALC) && acc_hit && (kind_reg == KIND_WRITE);

        case (state_reg)
            ST_IDLE: state_next = q_pop ? ST_CALC : ST_IDLE;
            ST_CALC: state_next = ST_OUT;
            ST_OUT: begin
                if (m_tready) begin
                    state_next = q_pop ? ST_CALC : ST_IDLE;
                end else begin
                    state_next = ST_OUT;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            prod_reg    <= prod_next;
            base_reg    <= q_head.base;
            hit_pre_reg <= q_head.hit_pre;
            kind_reg    <= q_head.kind;
            wdata_reg   <= q_head.wdata;
        end
        if (state_reg == ST_CALC) begin
            out_hit_reg  <= acc_hit;
            out_rd_reg   <= ram_re;
            out_addr_reg <= acc_hit ? sum[ADDR_OUT_W-1:0] : '0;
        end
    end

    sfma_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (aclk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (sum[AW-1:0]),
        .wdata (VALUE_WIDTH'(wdata_reg)),
        .rdata (ram_rdata)
    );

    // read data stays put until the next read, which follows the handshake
    assign read_value = out_rd_reg ? 32'(ram_rdata) : '0;
    assign m_tvalid   = (state_reg == ST_OUT);
    assign m_tuser    = out_hit_reg;
    assign m_tdata    = {{(OUT_TDATA_W - 32 - ADDR_OUT_W){1'b0}}, out_addr_reg, read_value};

    `SFMA_ASSERT_SAME(a_pop_slot, aclk, aresetn, q_pop, (state_reg == ST_IDLE) || ((state_reg == ST_OUT) && m_tready), "pop while a result is pending")
    `SFMA_ASSERT_NEXT(a_calc_to_out, aclk, aresetn, state_reg == ST_CALC, state_reg == ST_OUT, "access step not followed by result")
    `SFMA_ASSERT_SAME(a_write_once, aclk, aresetn, ram_we, (state_reg == ST_CALC) && !ram_re, "store write outside the access step")
    `SFMA_ASSERT_SAME(a_miss_zero, aclk, aresetn, m_tvalid && !m_tuser, m_tdata == '0, "miss beat carries data")

endmodule

// ----- design/sparse_format_matrix_element_access.sv -----
// ----------------------------------------------------------------------------
// sparse_format_matrix_element_access
// Element reads and writes by (row, col) into a matrix kept in zero,
// diagonal, banded, striped or dense packed form.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  s_       in   s_tvalid/s_tready    s_tdata access fields, s_tuser func
//  m_       out  m_tvalid/m_tready    m_tdata value and address, m_tuser hit
//  cfg_     in   cfg_wr_en            cfg_wr_index, cfg_wr_data
//
// One result beat per item. In the back end an item goes through multiply, store
// access and result in turn; the back end holds one item from its store access
// until its result beat is taken and takes no new item before then. The front
// end takes an item each cycle until the 4-entry queue fills. Reset is
// synchronous; the element store and the stripe table are not cleared.
// ----------------------------------------------------------------------------
module sparse_format_matrix_element_access #(
    parameter int MAX_DIM     = 256,
    parameter int STORE_DEPTH = 4096,
    parameter int MAX_STRIPES = 8,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // row[7:0], col[15:8], write_value[47:16], stripe_slot[50:48],
    // stripe_offset[59:51], zero fill[63:60]
    input  logic [sfma_pkg::IN_TDATA_W-1:0]  s_tdata,
    // func[1:0]
    input  logic [1:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // read_value[31:0], address[43:32], zero fill[47:44]
    output logic [sfma_pkg::OUT_TDATA_W-1:0] m_tdata,
    // hit[0]
    output logic                             m_tuser,
    input  logic                             cfg_wr_en,
    input  logic [2:0]                       cfg_wr_index,
    input  logic [sfma_pkg::DIM_W-1:0]       cfg_wr_data
);
    import sfma_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    logic  push, q_full, q_valid, q_pop;
    qent_t push_data, q_head;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_STORAGE_MODE: cfg_next.storage_mode = cfg_wr_data[2:0];
                REG_COLUMN_MAJOR: cfg_next.column_major = cfg_wr_data[0];
                REG_NUM_ROWS:     cfg_next.num_rows     = cfg_wr_data;
                REG_NUM_COLS:     cfg_next.num_cols     = cfg_wr_data;
                REG_STRIPE_COUNT: cfg_next.stripe_count = cfg_wr_data[3:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.storage_mode <= MODE_ZERO;
            cfg_reg.column_major <= 1'b0;
            cfg_reg.num_rows     <= DIM_W'(256);
            cfg_reg.num_cols     <= DIM_W'(256);
            cfg_reg.stripe_count <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    sfma_front #(
        .MAX_DIM     (MAX_DIM),
        .MAX_STRIPES (MAX_STRIPES)
    ) u_front (
        .aclk      (aclk),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    sfma_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    sfma_back #(
        .STORE_DEPTH (STORE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ----- bench/tb_sparse_format_matrix_element_access.sv -----
// ----------------------------------------------------------------------------
// Testbench for sparse_format_matrix_element_access
// Drives read, write, stripe-load and unknown-function beats through the stream ports under
// several storage modes, orders and dimensions. A scoreboard predicts each
// result from its own copy of the registers, the stripe table and the
// element store, and checks every output beat in order.
// ----------------------------------------------------------------------------
package element_check_pkg;
    import sfma_pkg::*;

    localparam int         STORE_WORDS    = 4096;
    localparam int         STRIPE_SLOTS   = 8;
    localparam int         DIM_LIMIT      = 256;
    localparam logic [1:0] FUNC_UNUSED    = 2'd3;
    localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
    localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  row;
        logic [7:0]  col;
        logic [31:0] wval;
        logic [2:0]  slot;
        off_t        off;
    } access_t;

    typedef struct packed {
        logic [31:0] value;
        logic        hit;
        logic [11:0] addr;
    } result_t;

    class element_scoreboard;
        logic [2:0]  mode;
        logic        col_major;
        logic [8:0]  rows_reg;
        logic [8:0]  cols_reg;
        logic [3:0]  stripes_reg;
        off_t        stripe_tab [STRIPE_SLOTS];
        logic [31:0] store [STORE_WORDS];
        bit          written [STORE_WORDS];
        result_t     expected_q [$];
        int          mismatches;

        function new();
            mode        = MODE_ZERO;
            col_major   = 1'b0;
            rows_reg    = 9'd256;
            cols_reg    = 9'd256;
            stripes_reg = 4'd0;
            mismatches  = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [8:0] data);
            case (idx)
                REG_STORAGE_MODE: mode        = data[2:0];
                REG_COLUMN_MAJOR: col_major   = data[0];
                REG_NUM_ROWS:     rows_reg    = data;
                REG_NUM_COLS:     cols_reg    = data;
                REG_STRIPE_COUNT: stripes_reg = data[3:0];
                default: ;
            endcase
        endfunction

        function int rows_in_use();
            return (rows_reg > DIM_LIMIT) ? DIM_LIMIT : int'(rows_reg);
        endfunction

        function int cols_in_use();
            return (cols_reg > DIM_LIMIT) ? DIM_LIMIT : int'(cols_reg);
        endfunction

        // Map (row, col) to a store address; returns 0 when the element is not stored.
        function bit locate(int r, int c, bit is_wr, output int a);
            int nr, nc, kl, ku, lo, diff, lim, m, k;
            nr = rows_in_use();
            nc = cols_in_use();
            a  = -1;
            if (r >= nr || c >= nc) return 1'b0;
            case (mode)
                MODE_DIAG: if (r == c) a = r;
                MODE_BAND: begin
                    if (is_wr) return 1'b0;
                    kl = int'(stripe_tab[0]);
                    ku = int'(stripe_tab[1]);
                    if (!col_major) begin
                        lo = (r - kl > 0) ? r - kl : 0;
                        if (lo <= c && c <= r + ku) a = c - r + kl + r * (kl + ku + 1);
                    end else begin
                        lo = (c - ku > 0) ? c - ku : 0;
                        if (lo <= r && r <= c + kl) a = r - c + ku + c * (kl + ku + 1);
                    end
                end
                MODE_STRIPE: begin
                    lim  = (stripes_reg > STRIPE_SLOTS) ? STRIPE_SLOTS : int'(stripes_reg);
                    m    = (nr < nc) ? nr : nc;
                    diff = c - r;
                    // first matching entry wins
                    for (k = 0; k < lim; k++)
                        if (a < 0 && int'(stripe_tab[k]) == diff)
                            a = ((diff < 0) ? c : r) + k * m;
                end
                MODE_DENSE: a = col_major ? r + c * nr : r * nc + c;
                default: ;
            endcase
            return (a >= 0 && a < STORE_WORDS);
        endfunction

        function void note(access_t it);
            result_t want;
            int      a;
            want = '0;
            case (it.func)
                FUNC_READ: if (locate(int'(it.row), int'(it.col), 1'b0, a)) begin
                    want.value = store[a];
                    want.hit   = 1'b1;
                    want.addr  = a[11:0];
                end
                FUNC_WRITE: if (locate(int'(it.row), int'(it.col), 1'b1, a)) begin
                    store[a]   = it.wval;
                    written[a] = 1'b1;
                    want.hit   = 1'b1;
                    want.addr  = a[11:0];
                end
                FUNC_LOAD: stripe_tab[it.slot] = it.off;
                default: ;
            endcase
            expected_q.push_back(want);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            mismatches++;
            $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
        endtask

        task check(logic [31:0] value, logic hit, logic [11:0] addr);
            result_t want;
            if (expected_q.size() == 0) begin
                report_mismatch("beat with nothing pending", {20'b0, addr}, 32'd0);
                return;
            end
            want = expected_q.pop_front();
            if (value !== want.value) report_mismatch("read_value", value, want.value);
            if (hit !== want.hit) report_mismatch("hit", {31'b0, hit}, {31'b0, want.hit});
            if (addr !== want.addr) report_mismatch("address", {20'b0, addr}, {20'b0, want.addr});
        endtask
    endclass
endpackage

module tb_sparse_format_matrix_element_access;
    import sfma_pkg::*;
    import element_check_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int LONG_HOLD  = 300;

    logic                   aclk         = 1'b0;
    logic                   aresetn      = 1'b0;
    logic                   s_tvalid     = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata      = '0;
    logic [1:0]             s_tuser      = '0;
    logic                   m_tvalid;
    logic                   m_tready     = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   cfg_wr_en    = 1'b0;
    logic [2:0]             cfg_wr_index = '0;
    logic [DIM_W-1:0]       cfg_wr_data  = '0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit long_hold      = 1'b0;
    int held_cycles    = 0;
    int quiet_cycles   = 0;

    element_scoreboard sb = new();

    sparse_format_matrix_element_access dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    always #2 aclk = ~aclk;

    // receiver: one long hold-off once requested, random stalls otherwise
    always @(posedge aclk) begin
        if (long_hold && held_cycles < LONG_HOLD) begin
            m_tready    <= 1'b0;
            held_cycles <= held_cycles + 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check(m_tdata[31:0], m_tuser, m_tdata[43:32]);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic access_t make_access(logic [1:0] f, int r, int c, logic [31:0] v,
                                            int sl, int of);
        access_t it;
        it.func = f;
        it.row  = 8'(r);
        it.col  = 8'(c);
        it.wval = v;
        it.slot = 3'(sl);
        it.off  = off_t'(of);
        return it;
    endfunction

    function automatic access_t next_access();
        access_t it;
        int      pick, nr, nc, r, c, kl, ku, a;
        it.row  = 8'($urandom);
        it.col  = 8'($urandom);
        it.wval = $urandom;
        it.slot = 3'($urandom);
        it.off  = off_t'($urandom);
        pick    = $urandom_range(99);
        if (pick < 45) it.func = FUNC_READ;
        else if (pick < 87) it.func = FUNC_WRITE;
        else if (pick < 95) it.func = FUNC_LOAD;
        else it.func = FUNC_UNUSED;
        if (it.func == FUNC_LOAD && $urandom_range(1) == 0)
            it.off = off_t'(int'($urandom_range(8)) - 4);
        // aim most accesses at stored positions of the current layout
        if ($urandom_range(99) < 85) begin
            nr = sb.rows_in_use();
            nc = sb.cols_in_use();
            r  = $urandom_range(nr - 1);
            c  = $urandom_range(nc - 1);
            kl = int'(sb.stripe_tab[0]);
            ku = int'(sb.stripe_tab[1]);
            case (sb.mode)
                MODE_DIAG: c = r;
                MODE_BAND: if (kl >= 0 && ku >= 0 && kl + ku < 16)
                    c = r + int'($urandom_range(kl + ku)) - kl;
                MODE_STRIPE: c = r + int'(sb.stripe_tab[$urandom_range(STRIPE_SLOTS - 1)]);
                default: ;
            endcase
            if (c < 0 || c >= nc) c = $urandom_range(nc - 1);
            it.row = 8'(r);
            it.col = 8'(c);
        end
        // never read a store word that holds nothing yet
        if (it.func == FUNC_READ && sb.locate(int'(it.row), int'(it.col), 1'b0, a)
            && !sb.written[a])
            it.func = FUNC_WRITE;
        return it;
    endfunction

    task automatic send(input access_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, it.off, it.slot, it.wval, it.col, it.row};
        s_tuser  <= it.func;
        do @(posedge aclk); while (!s_tready);
        sb.note(it);
    endtask

    // drop valid and hold until every pending result has come back
    task automatic wait_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.expected_q.size() != 0);
    endtask

    task automatic settle();
        wait_results();
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [8:0] data);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(posedge aclk);
        sb.set_reg(idx, data);
    endtask

    task automatic configure(input logic [2:0] md, input logic cm, input logic [8:0] nr,
                             input logic [8:0] nc, input logic [3:0] sc);
        write_reg(REG_STORAGE_MODE, {6'b0, md});
        write_reg(REG_COLUMN_MAJOR, {8'b0, cm});
        write_reg(REG_NUM_ROWS, nr);
        write_reg(REG_NUM_COLS, nc);
        write_reg(REG_STRIPE_COUNT, {5'b0, sc});
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input logic [2:0] md, input logic cm, input logic [8:0] nr,
                             input logic [8:0] nc, input logic [3:0] sc, input int n,
                             input int s_pct, input int r_pct, input int pause_at,
                             input bit hold);
        configure(md, cm, nr, nc, sc);
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        if (hold) long_hold <= 1'b1;
        for (int i = 0; i < n; i++) begin
            if (i == pause_at) wait_results();
            send(next_access());
        end
        settle();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // stripe table first: band limits in entries 0 and 1, offset extremes after
        send(make_access(FUNC_LOAD, 0, 0, 0, 0, 2));
        send(make_access(FUNC_LOAD, 0, 0, 0, 1, 1));
        send(make_access(FUNC_LOAD, 0, 0, 0, 2, 0));
        send(make_access(FUNC_LOAD, 0, 0, 0, 3, -1));
        send(make_access(FUNC_LOAD, 0, 0, 0, 4, 255));
        send(make_access(FUNC_LOAD, 0, 0, 0, 5, -255));
        send(make_access(FUNC_LOAD, 0, 0, 0, 6, -256));
        send(make_access(FUNC_LOAD, 0, 0, 0, 7, 3));
        // unknown functions, then a read and a write, all in zero mode
        send(make_access(FUNC_UNUSED, 255, 255, 32'hFFFF_FFFF, 7, -1));
        send(make_access(FUNC_UNUSED, 0, 0, 32'h0, 0, 0));
        send(make_access(FUNC_READ, 0, 0, 32'h0, 0, 0));
        send(make_access(FUNC_WRITE, 255, 255, 32'hFFFF_FFFF, 0, 0));
        settle();

        // fill store words 0..255 so later layouts have data to read
        configure(MODE_DENSE, 1'b0, 9'd16, 9'd16, 4'd0);
        for (int r = 0; r < 16; r++)
            for (int c = 0; c < 16; c++)
                send(make_access(FUNC_WRITE, r, c, $urandom, 0, 0));
        settle();

        // last store word, just past the store, outside the store
        configure(MODE_DENSE, 1'b0, 9'd256, 9'd256, 4'd0);
        send(make_access(FUNC_WRITE, 15, 255, 32'hFFFF_FFFF, 0, 0));
        send(make_access(FUNC_READ, 15, 255, 32'h0, 0, 0));
        send(make_access(FUNC_WRITE, 16, 0, 32'h0, 0, 0));
        send(make_access(FUNC_READ, 255, 255, 32'h0, 0, 0));
        send(make_access(FUNC_READ, 0, 0, 32'h0, 0, 0));
        settle();

        run_phase(MODE_DIAG, 1'b0, 9'd256, 9'd256, 4'd0, 90, 0, 0, -1, 1'b0);
        run_phase(MODE_DENSE, 1'b1, 9'd16, 9'd200, 4'd0, 100, 69, 0, -1, 1'b0);
        run_phase(MODE_STRIPE, 1'b0, 9'd40, 9'd60, 4'd8, 100, 0, 69, -1, 1'b0);
        run_phase(MODE_BAND, 1'b0, 9'd32, 9'd32, 4'd0, 90, 23, 23, -1, 1'b0);
        run_phase(MODE_BAND, 1'b1, 9'd50, 9'd20, 4'd2, 90, 0, 0, -1, 1'b0);
        run_phase(MODE_STRIPE, 1'b1, 9'd256, 9'd256, 4'd15, 100, 69, 0, -1, 1'b0);
        run_phase(MODE_DENSE, 1'b0, 9'd511, 9'd511, 4'd0, 100, 0, 69, -1, 1'b0);
        run_phase(MODE_UNUSED_LO, 1'b0, 9'd1, 9'd1, 4'd3, 60, 23, 23, -1, 1'b0);
        run_phase(MODE_UNUSED_HI, 1'b1, 9'd256, 9'd256, 4'd9, 40, 0, 0, -1, 1'b0);
        run_phase(MODE_STRIPE, 1'b0, 9'd1, 9'd256, 4'd0, 80, 23, 23, -1, 1'b0);
        // receiver holds off while beats keep coming, so the input backs up
        run_phase(MODE_DENSE, 1'b0, 9'd1, 9'd1, 4'd0, 60, 0, 0, -1, 1'b1);
        run_phase(MODE_DENSE, 1'b1, 9'd64, 9'd64, 4'd0, 100, 69, 0, 75, 1'b0);
        run_phase(MODE_DIAG, 1'b1, 9'd5, 9'd9, 4'd1, 60, 0, 0, -1, 1'b0);

        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
